// File: rtl/core/sensor_health_scorer_top_macros.svh
// Assertion macros for the sensor health scorer RTL.
// No dependencies; shs_back pulls this in by include.
`ifndef SENSOR_HEALTH_SCORER_TOP_MACROS_SVH
`define SENSOR_HEALTH_SCORER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sensor health scorer: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sensor health scorer: next-cycle check failed");

`else

`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/shs_pkg.sv
// Package for the sensor health scorer: word types, config layout, codes and constants.
// No dependencies; used by the top level, front and back ends.
`default_nettype none

package shs_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int TIME_W    = 32;
    localparam int SCORE_W   = 7;
    localparam int ICNT_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Defaults for top-level parameters
    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_QUEUE_DEPTH  = 2;

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_MAX       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_DELTA    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IRR       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_DELTA    = 3'd7;

    // Score and penalties
    localparam logic [SCORE_W-1:0] SCORE_FULL  = 7'd100;
    localparam logic [SCORE_W-1:0] PEN_HB      = 7'd20;
    localparam logic [SCORE_W-1:0] PEN_RANGE   = 7'd40;
    localparam logic [SCORE_W-1:0] PEN_FLAT    = 7'd20;
    localparam logic [SCORE_W-1:0] PEN_RESP    = 7'd20;
    localparam logic [ICNT_W-1:0]  IRR_CNT_MAX = 8'd255;

    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] sample;
        logic                irrigation_done;
        logic [TIME_W-1:0]   now_ms;
        logic [TIME_W-1:0]   last_rx_ms;
    } in_word_t;

    typedef struct packed {
        logic [SCORE_W-1:0] health_score;
        logic               heartbeat_fault;
        logic               range_fault;
        logic               flatline_fault;
        logic               response_fault;
        logic               evaluated;
    } out_word_t;

    // Classified word between front and back
    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] sample;
        logic                irrigation_done;
        logic [TIME_W-1:0]   now_ms;
        logic                hb_fault;
        logic                range_fault;
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0]   cooldown_ms;
        logic [TIME_W-1:0]   eval_interval_ms;
        logic [TIME_W-1:0]   heartbeat_limit_ms;
        logic [SAMPLE_W-1:0] adc_min_valid;
        logic [SAMPLE_W-1:0] adc_max_valid;
        logic [SAMPLE_W-1:0] flatline_delta;
        logic [ICNT_W-1:0]   min_irrigations;
        logic [SAMPLE_W-1:0] response_delta;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cooldown_ms:        32'd60000,
        eval_interval_ms:   32'd10000,
        heartbeat_limit_ms: 32'd60000,
        adc_min_valid:      12'd1000,
        adc_max_valid:      12'd4000,
        flatline_delta:     12'd10,
        min_irrigations:    8'd3,
        response_delta:     12'd50
    };

endpackage

`default_nettype wire

// File: rtl/core/sensor_health_scorer_top.sv
// Sensor health scorer top level: configuration registers, front, back and result queue.
// Depends on shs_pkg, shs_fifo, shs_front and shs_back.
//
// Soil moisture sensor health monitor. Each input word (sample update or clear) yields
// exactly one result word with the score and the four fault flags as held after that
// word. Input and result sides are queues: push/full and empty/pop. Each word passes
// the back end update and output states, with a score state between them for a periodic
// evaluation and a window scan before scoring when that evaluation needs the flatline
// rule; the scan reads the sample window memory one entry per cycle through its single
// read port. The back end takes the next word only after the last result is queued.
// Configuration writes take effect at once and are meant for idle periods only; reset
// loads the documented register defaults.
`default_nettype none

module sensor_health_scorer_top
    import shs_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire in_word_t             in_word,
    output logic                      empty,
    input  wire logic                 pop,
    output out_word_t                 out_word,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    cmd_t      cmd_word;
    logic      cmd_empty;
    logic      cmd_pop;
    logic      res_full;
    logic      res_push;
    out_word_t res_word;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_COOLDOWN:      cfg_reg.cooldown_ms        <= cfg_data[TIME_W-1:0];
                CFG_EVAL_INTERVAL: cfg_reg.eval_interval_ms   <= cfg_data[TIME_W-1:0];
                CFG_HB_LIMIT:      cfg_reg.heartbeat_limit_ms <= cfg_data[TIME_W-1:0];
                CFG_ADC_MIN:       cfg_reg.adc_min_valid      <= cfg_data[SAMPLE_W-1:0];
                CFG_ADC_MAX:       cfg_reg.adc_max_valid      <= cfg_data[SAMPLE_W-1:0];
                CFG_FLAT_DELTA:    cfg_reg.flatline_delta     <= cfg_data[SAMPLE_W-1:0];
                CFG_MIN_IRR:       cfg_reg.min_irrigations    <= cfg_data[ICNT_W-1:0];
                CFG_RESP_DELTA:    cfg_reg.response_delta     <= cfg_data[SAMPLE_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: classify and queue
    shs_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd_word  (cmd_word)
    );

    // Back end: state, window scan, scoring
    shs_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_word  (cmd_word),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    // Result queue
    shs_fifo #(
        .WIDTH ($bits(out_word_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res_word),
        .pop   (pop),
        .empty (empty),
        .dout  (out_word)
    );

endmodule

`default_nettype wire

// File: rtl/core/shs_fifo.sv
// Small word queue with push/full and pop/empty sides.
// Depends on nothing; used between front and back and on the result side.
`default_nettype none

module shs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] din,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] dout
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/shs_front.sv
// Front end: accepts input words, precomputes heartbeat and range checks, queues commands.
// Depends on shs_pkg and shs_fifo.
`default_nettype none

module shs_front
    import shs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     push,
    output logic          full,
    input  wire in_word_t in_word,
    input  wire logic     cmd_pop,
    output logic          cmd_empty,
    output cmd_t          cmd_word
);

    cmd_t              cls_word;
    logic [TIME_W-1:0] rx_gap;
    logic              hb_fault;
    logic              range_fault;

    // Heartbeat: a receive time of zero means nothing was ever received
    assign rx_gap = in_word.now_ms - in_word.last_rx_ms;

    always_comb
    begin
        if (in_word.last_rx_ms == '0)
        begin
            hb_fault = (in_word.now_ms >= cfg.heartbeat_limit_ms);
        end
        else
        begin
            hb_fault = (rx_gap > cfg.heartbeat_limit_ms);
        end
    end

    // Range check; crossed bounds flag every sample
    assign range_fault = (in_word.sample < cfg.adc_min_valid) ||
                         (in_word.sample > cfg.adc_max_valid);

    always_comb
    begin
        cls_word.opcode          = in_word.opcode;
        cls_word.sample          = in_word.sample;
        cls_word.irrigation_done = in_word.irrigation_done;
        cls_word.now_ms          = in_word.now_ms;
        cls_word.hb_fault        = hb_fault;
        cls_word.range_fault     = range_fault;
    end

    // Command queue toward the back end
    shs_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (cls_word),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (cmd_word)
    );

endmodule

`default_nettype wire

// File: rtl/core/shs_back.sv
// Back end: monitor state, sample window memory, window min/max scan and scoring.
// Depends on shs_pkg and the assertion macro header.
`default_nettype none
`include "sensor_health_scorer_top_macros.svh"

module shs_back
    import shs_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  cmd_empty,
    input  wire cmd_t  cmd_word,
    output logic       cmd_pop,
    input  wire logic  res_full,
    output logic       res_push,
    output out_word_t  res_word
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = AW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SCORE  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]          state_reg, state_next;
    cmd_t                cmd_reg;
    logic [AW-1:0]       wr_idx_reg, wr_idx_next;
    logic                ring_full_reg, ring_full_next;
    logic                awaiting_reg, awaiting_next;
    logic                checked_reg, checked_next;
    logic [SAMPLE_W-1:0] before_reg, before_next;
    logic [TIME_W-1:0]   irr_time_reg, irr_time_next;
    logic [ICNT_W-1:0]   irr_cnt_reg, irr_cnt_next;
    logic [TIME_W-1:0]   last_eval_reg, last_eval_next;
    logic                hb_reg, hb_next;
    logic                rng_reg, rng_next;
    logic                flat_reg, flat_next;
    logic                resp_reg, resp_next;
    logic [SCORE_W-1:0]  score_reg, score_next;
    logic                eval_reg, eval_next;
    logic                flat_chk_reg, flat_chk_next;
    logic [CNT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                rd_first_reg, rd_first_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] hi_reg, hi_next;
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
    logic                ring_we;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    // Update-step helpers
    logic                irr_start;
    logic                awaiting_eff, checked_eff;
    logic [SAMPLE_W-1:0] before_eff;
    logic [TIME_W-1:0]   irr_time_eff;
    logic [ICNT_W-1:0]   irr_cnt_eff;
    logic [TIME_W-1:0]   irr_age;
    logic [TIME_W-1:0]   eval_age;
    logic [SAMPLE_W-1:0] drop;
    logic                resp_due, responded, eval_due;
    logic                wr_wrap, ring_full_eff;
    logic [SAMPLE_W-1:0] spread;
    logic [SCORE_W-1:0]  penalty;

    assign irr_start    = cmd_reg.irrigation_done && !awaiting_reg;
    assign awaiting_eff = irr_start || awaiting_reg;
    assign checked_eff  = irr_start ? 1'b0 : checked_reg;
    assign before_eff   = irr_start ? cmd_reg.sample : before_reg;
    assign irr_time_eff = irr_start ? cmd_reg.now_ms : irr_time_reg;
    assign irr_cnt_eff  = (irr_start && (irr_cnt_reg != IRR_CNT_MAX)) ?
                          irr_cnt_reg + 1'b1 : irr_cnt_reg;
    assign irr_age      = cmd_reg.now_ms - irr_time_eff;
    assign eval_age     = cmd_reg.now_ms - last_eval_reg;
    assign drop         = before_eff - cmd_reg.sample;
    assign resp_due     = awaiting_eff && !checked_eff && (irr_age >= cfg.cooldown_ms);
    assign responded    = (before_eff > cmd_reg.sample) && (drop >= cfg.response_delta);
    assign eval_due     = (eval_age >= cfg.eval_interval_ms);
    assign wr_wrap      = (wr_idx_reg == AW'(WINDOW_DEPTH - 1));
    assign ring_full_eff = ring_full_reg || wr_wrap;
    assign spread       = hi_reg - lo_reg;

    // Sum of penalties never exceeds the full score, so no floor is needed
    assign penalty = (hb_reg   ? PEN_HB    : '0) +
                     (rng_reg  ? PEN_RANGE : '0) +
                     (flat_next ? PEN_FLAT : '0) +
                     (resp_reg ? PEN_RESP  : '0);

    assign cmd_pop  = (state_reg == S_IDLE) && !cmd_empty;
    assign res_push = (state_reg == S_OUT) && !res_full;

    always_comb
    begin
        res_word.health_score    = score_reg;
        res_word.heartbeat_fault = hb_reg;
        res_word.range_fault     = rng_reg;
        res_word.flatline_fault  = flat_reg;
        res_word.response_fault  = resp_reg;
        res_word.evaluated       = eval_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        ring_full_next = ring_full_reg;
        awaiting_next  = awaiting_reg;
        checked_next   = checked_reg;
        before_next    = before_reg;
        irr_time_next  = irr_time_reg;
        irr_cnt_next   = irr_cnt_reg;
        last_eval_next = last_eval_reg;
        hb_next        = hb_reg;
        rng_next       = rng_reg;
        flat_next      = flat_reg;
        resp_next      = resp_reg;
        score_next     = score_reg;
        eval_next      = eval_reg;
        flat_chk_next  = flat_chk_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_first_next  = 1'b0;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ring_we        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = scan_cnt_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (cmd_reg.opcode == OP_CLEAR)
                begin
                    hb_next        = 1'b0;
                    rng_next       = 1'b0;
                    flat_next      = 1'b0;
                    resp_next      = 1'b0;
                    score_next     = SCORE_FULL;
                    irr_cnt_next   = '0;
                    ring_full_next = 1'b0;
                    wr_idx_next    = '0;
                    awaiting_next  = 1'b0;
                    checked_next   = 1'b0;
                    eval_next      = 1'b0;
                    state_next     = S_OUT;
                end
                else
                begin
                    // Window write
                    ring_we        = 1'b1;
                    wr_idx_next    = wr_wrap ? '0 : wr_idx_reg + 1'b1;
                    ring_full_next = ring_full_eff;

                    // Irrigation bookkeeping and response check
                    before_next   = before_eff;
                    irr_time_next = irr_time_eff;
                    irr_cnt_next  = irr_cnt_eff;
                    if (resp_due)
                    begin
                        resp_next     = !responded;
                        checked_next  = 1'b1;
                        awaiting_next = 1'b0;
                    end
                    else
                    begin
                        checked_next  = checked_eff;
                        awaiting_next = awaiting_eff;
                    end

                    // Periodic evaluation
                    eval_next = eval_due;
                    if (eval_due)
                    begin
                        last_eval_next = cmd_reg.now_ms;
                        hb_next        = cmd_reg.hb_fault;
                        rng_next       = cmd_reg.range_fault;
                        if (ring_full_eff && (irr_cnt_eff >= cfg.min_irrigations))
                        begin
                            flat_chk_next = 1'b1;
                            scan_cnt_next = '0;
                            state_next    = S_SCAN;
                        end
                        else
                        begin
                            flat_chk_next = 1'b0;
                            state_next    = S_SCORE;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_SCAN:
            begin
                // One read per cycle, fold the registered data in the next cycle
                rd_en = (scan_cnt_reg < CNT_W'(WINDOW_DEPTH));
                if (rd_en)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    rd_vld_next   = 1'b1;
                    rd_first_next = (scan_cnt_reg == '0);
                end
                if (rd_vld_reg)
                begin
                    if (rd_first_reg)
                    begin
                        lo_next = rd_data_reg;
                        hi_next = rd_data_reg;
                    end
                    else
                    begin
                        if (rd_data_reg < lo_reg)
                        begin
                            lo_next = rd_data_reg;
                        end
                        if (rd_data_reg > hi_reg)
                        begin
                            hi_next = rd_data_reg;
                        end
                    end
                end
                if (!rd_en && !rd_vld_reg)
                begin
                    state_next = S_SCORE;
                end
            end

            S_SCORE:
            begin
                flat_next  = flat_chk_reg && (spread < cfg.flatline_delta);
                score_next = SCORE_FULL - penalty;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_idx_reg    <= '0;
            ring_full_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
            checked_reg   <= 1'b0;
            before_reg    <= '0;
            irr_time_reg  <= '0;
            irr_cnt_reg   <= '0;
            last_eval_reg <= '0;
            hb_reg        <= 1'b0;
            rng_reg       <= 1'b0;
            flat_reg      <= 1'b0;
            resp_reg      <= 1'b0;
            score_reg     <= SCORE_FULL;
            eval_reg      <= 1'b0;
            flat_chk_reg  <= 1'b0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            ring_full_reg <= ring_full_next;
            awaiting_reg  <= awaiting_next;
            checked_reg   <= checked_next;
            before_reg    <= before_next;
            irr_time_reg  <= irr_time_next;
            irr_cnt_reg   <= irr_cnt_next;
            last_eval_reg <= last_eval_next;
            hb_reg        <= hb_next;
            rng_reg       <= rng_next;
            flat_reg      <= flat_next;
            resp_reg      <= resp_next;
            score_reg     <= score_next;
            eval_reg      <= eval_next;
            flat_chk_reg  <= flat_chk_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            rd_first_reg  <= rd_first_next;
        end
    end

    // Payload: current command, scan extremes
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_word;
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    // Sample window memory, registered read
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wr_idx_reg] <= cmd_reg.sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Checks
    `SHS_ASSERT_IMPL(a_await_excl, clk, rst_n, awaiting_reg, !checked_reg)
    `SHS_ASSERT_IMPL(a_scan_bound, clk, rst_n, state_reg == S_SCAN, scan_cnt_reg <= CNT_W'(WINDOW_DEPTH))
    `SHS_ASSERT_NEXT(a_take_cmd, clk, rst_n, cmd_pop, state_reg == S_UPDATE)
    `SHS_ASSERT_IMPL(a_lo_hi, clk, rst_n, (state_reg == S_SCORE) && flat_chk_reg, lo_reg <= hi_reg)
    `SHS_ASSERT_IMPL(a_score_max, clk, rst_n, res_push, score_reg <= SCORE_FULL)

endmodule

`default_nettype wire
